/* src/knn_pkg.sv */
// ----------------------------------------------------------------------------
// knn_pkg
// shared types and constants of the k-nearest-neighbour selector
// ----------------------------------------------------------------------------
`default_nettype none

package knn_pkg;

  // width of a squared distance and its saturation value
  localparam int unsigned DIST_BITS = 40;
  localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

  // configuration register file
  localparam int unsigned CFG_K_BITS = 6;
  localparam logic [CFG_K_BITS-1:0] K_IN_USE_RESET = 6'd1;
  localparam logic REG_K_IN_USE = 1'b0;

  // sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } knn_state_e;

  // per-request flags that travel alongside the distance pipeline
  typedef struct packed {
    logic skip;
    logic last_coord;
    logic last_cand;
  } item_flags_t;

  // controls broadcast to every cell of the chain
  typedef struct packed {
    logic insert;
    logic shift;
    logic clear;
  } chain_ctrl_t;

endpackage

`default_nettype wire

/* src/knn_dist_acc.sv */
// ----------------------------------------------------------------------------
// knn_dist_acc
// two-stage squared difference and saturating distance accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module knn_dist_acc #(
  parameter int unsigned CoordBits = 16,
  parameter int unsigned LabelBits = 20
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              valid_i,
  input  wire  signed [CoordBits-1:0]      query_coord_i,
  input  wire  signed [CoordBits-1:0]      cand_coord_i,
  input  wire         [LabelBits-1:0]      label_i,
  input  knn_pkg::item_flags_t             flags_i,
  output logic                             valid_o,
  output logic [knn_pkg::DIST_BITS-1:0]    dist_o,
  output logic [LabelBits-1:0]             label_o,
  output knn_pkg::item_flags_t             flags_o
);

  localparam int unsigned SqBits  = 2 * (CoordBits + 1);
  localparam int unsigned SumBits =
    ((SqBits > knn_pkg::DIST_BITS) ? SqBits : knn_pkg::DIST_BITS) + 1;

  logic [CoordBits:0]              diff;
  logic [CoordBits:0]              absd;
  logic [SqBits-1:0]               sq_d;
  logic                            s1_valid_q;
  logic [SqBits-1:0]               s1_sq_q;
  logic [LabelBits-1:0]            s1_label_q;
  knn_pkg::item_flags_t            s1_flags_q;
  logic [SumBits-1:0]              sum;
  logic [knn_pkg::DIST_BITS-1:0]   sum_sat;
  logic [knn_pkg::DIST_BITS-1:0]   acc_d, acc_q;
  logic                            s2_valid_q;
  logic [knn_pkg::DIST_BITS-1:0]   s2_dist_q;
  logic [LabelBits-1:0]            s2_label_q;
  knn_pkg::item_flags_t            s2_flags_q;

  // exact difference, magnitude and square
  assign diff = {query_coord_i[CoordBits-1], query_coord_i}
              - {cand_coord_i[CoordBits-1], cand_coord_i};
  assign absd = diff[CoordBits] ? (~diff + 1'b1) : diff;
  assign sq_d = SqBits'(absd) * SqBits'(absd);

  // stage one: registered square
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      s1_sq_q    <= sq_d;
      s1_label_q <= label_i;
      s1_flags_q <= flags_i;
    end
  end

  // saturating sum
  assign sum     = SumBits'(acc_q) + SumBits'(s1_sq_q);
  assign sum_sat = (|sum[SumBits-1:knn_pkg::DIST_BITS]) ? knn_pkg::DIST_MAX
                                                        : sum[knn_pkg::DIST_BITS-1:0];

  // accumulator restarts after a finished candidate or the end of a query
  always_comb begin
    acc_d = acc_q;
    if (s1_valid_q) begin
      if (s1_flags_q.last_coord || s1_flags_q.last_cand) begin
        acc_d = '0;
      end else begin
        acc_d = sum_sat;
      end
    end
  end

  // stage two: accumulator and finished distance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_dist_q  <= sum_sat;
      s2_label_q <= s1_label_q;
      s2_flags_q <= s1_flags_q;
    end
  end

  assign valid_o = s2_valid_q;
  assign dist_o  = s2_dist_q;
  assign label_o = s2_label_q;
  assign flags_o = s2_flags_q;

endmodule

`default_nettype wire

/* src/knn_cell.sv */
// ----------------------------------------------------------------------------
// knn_cell
// one slot of the sorted neighbour chain: compare, insert or shift
// ----------------------------------------------------------------------------
`default_nettype none

module knn_cell #(
  parameter int unsigned LabelBits = 20
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  knn_pkg::chain_ctrl_t             ctrl_i,
  input  wire  [knn_pkg::DIST_BITS-1:0]    new_dist_i,
  input  wire  [LabelBits-1:0]             new_label_i,
  input  wire  [knn_pkg::DIST_BITS-1:0]    prev_dist_i,
  input  wire  [LabelBits-1:0]             prev_label_i,
  input  wire                              prev_valid_i,
  input  wire                              prev_take_i,
  input  wire  [knn_pkg::DIST_BITS-1:0]    next_dist_i,
  input  wire  [LabelBits-1:0]             next_label_i,
  input  wire                              next_valid_i,
  output logic [knn_pkg::DIST_BITS-1:0]    dist_o,
  output logic [LabelBits-1:0]             label_o,
  output logic                             valid_o,
  output logic                             take_o
);

  logic [knn_pkg::DIST_BITS-1:0] dist_d, dist_q;
  logic [LabelBits-1:0]          label_d, label_q;
  logic                          valid_d, valid_q;

  // this slot or an earlier one receives the new entry
  assign take_o = ctrl_i.insert && (!valid_q || (new_dist_i <= dist_q));

  // slot update: clear, shift towards the head, or insert with push-down
  always_comb begin
    dist_d  = dist_q;
    label_d = label_q;
    valid_d = valid_q;
    if (ctrl_i.clear) begin
      dist_d  = knn_pkg::DIST_MAX;
      label_d = '0;
      valid_d = 1'b0;
    end else if (ctrl_i.shift) begin
      dist_d  = next_dist_i;
      label_d = next_label_i;
      valid_d = next_valid_i;
    end else if (prev_take_i) begin
      dist_d  = prev_dist_i;
      label_d = prev_label_i;
      valid_d = prev_valid_i;
    end else if (take_o) begin
      dist_d  = new_dist_i;
      label_d = new_label_i;
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q  <= knn_pkg::DIST_MAX;
      label_q <= '0;
      valid_q <= 1'b0;
    end else begin
      dist_q  <= dist_d;
      label_q <= label_d;
      valid_q <= valid_d;
    end
  end

  assign dist_o  = dist_q;
  assign label_o = label_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

/* src/knn_topk_distance_selector_core.sv */
// ----------------------------------------------------------------------------
// knn_topk_distance_selector_core
// brute-force k-nearest-neighbour selection over a chain of sorted cells
// ----------------------------------------------------------------------------
//  channel   direction  handshake          content
//  s_axis    in         tvalid / tready    one coordinate pair of a candidate
//  m_axis    out        tvalid / tready    one ranked neighbour
//  apb       in         psel / penable     k_in_use register at byte 0
//
//  one coordinate request is taken every cycle while a query streams in
//  a finished candidate passes the square and accumulator stages, then is inserted into the chain
//  at the end of a query input stalls while the pipeline drains and the k results
//  are emitted; output back-pressure lengthens the stall
//  reset empties the whole chain at once, with no clearing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module knn_topk_distance_selector_core #(
  parameter int unsigned K_MAX      = 32,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned LABEL_BITS = 20
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // query_coord, cand_coord, cand_label (lowest bits first), zero padded
  input  wire  [((2*COORD_BITS+LABEL_BITS+7)/8)*8-1:0] s_axis_tdata,
  // skip_candidate, last_coord
  input  wire  [1:0]                 s_axis_tuser,
  input  wire                        s_axis_tlast,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  // neighbour_distance, neighbour_label (lowest bits first), zero padded
  output logic [((knn_pkg::DIST_BITS+LABEL_BITS+7)/8)*8-1:0] m_axis_tdata,
  // slot_filled
  output logic                       m_axis_tuser,
  output logic                       m_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [2:0]                 paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned KW     = $clog2(K_MAX + 1);
  localparam int unsigned OutW   = ((knn_pkg::DIST_BITS + LABEL_BITS + 7) / 8) * 8;
  localparam int unsigned OutPad = OutW - knn_pkg::DIST_BITS - LABEL_BITS;

  knn_pkg::knn_state_e            state_d, state_q;
  logic [knn_pkg::CFG_K_BITS-1:0] k_q;
  logic [KW-1:0]                  k_eff;
  logic [KW-1:0]                  k_lat_d, k_lat_q;
  logic [KW-1:0]                  cnt_d, cnt_q;
  logic                           in_acc;
  logic                           cfg_wr;
  logic                           load;
  logic                           load_last;
  knn_pkg::item_flags_t           in_flags;
  logic                           pv_valid;
  logic [knn_pkg::DIST_BITS-1:0]  pv_dist;
  logic [LABEL_BITS-1:0]          pv_label;
  knn_pkg::item_flags_t           pv_flags;
  knn_pkg::chain_ctrl_t           ctrl;
  logic [knn_pkg::DIST_BITS-1:0]  c_dist  [K_MAX];
  logic [LABEL_BITS-1:0]          c_label [K_MAX];
  logic                           c_valid [K_MAX];
  logic                           c_take  [K_MAX];
  logic                           out_valid_q;
  logic [knn_pkg::DIST_BITS-1:0]  out_dist_q;
  logic [LABEL_BITS-1:0]          out_label_q;
  logic                           out_fill_q;
  logic                           out_last_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == knn_pkg::REG_K_IN_USE);
  assign prdata = (paddr[2] == knn_pkg::REG_K_IN_USE) ? 32'(k_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= knn_pkg::K_IN_USE_RESET;
    end else if (cfg_wr) begin
      k_q <= pwdata[knn_pkg::CFG_K_BITS-1:0];
    end
  end

  // k clamped to one .. K_MAX
  always_comb begin
    if (k_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(k_q) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(k_q);
    end
  end

  // input side
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_flags = '{skip: s_axis_tuser[0], last_coord: s_axis_tuser[1],
                      last_cand: s_axis_tlast};

  knn_dist_acc #(
    .CoordBits(COORD_BITS),
    .LabelBits(LABEL_BITS)
  ) u_dist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (in_acc),
    .query_coord_i(s_axis_tdata[COORD_BITS-1:0]),
    .cand_coord_i (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .label_i      (s_axis_tdata[2*COORD_BITS+LABEL_BITS-1:2*COORD_BITS]),
    .flags_i      (in_flags),
    .valid_o      (pv_valid),
    .dist_o       (pv_dist),
    .label_o      (pv_label),
    .flags_o      (pv_flags)
  );

  // emission step: head of chain moves into the output register
  assign load      = (state_q == knn_pkg::ST_EMIT) && (!out_valid_q || m_axis_tready);
  assign load_last = load && (cnt_q == (k_lat_q - KW'(1)));

  assign ctrl.insert = pv_valid && pv_flags.last_coord && !pv_flags.skip;
  assign ctrl.shift  = load;
  assign ctrl.clear  = load_last;

  // sequencer
  always_comb begin
    state_d       = state_q;
    k_lat_d       = k_lat_q;
    cnt_d         = cnt_q;
    s_axis_tready = 1'b0;
    case (state_q)
      knn_pkg::ST_RUN: begin
        s_axis_tready = 1'b1;
        if (in_acc && s_axis_tlast) begin
          state_d = knn_pkg::ST_DRAIN;
        end
      end
      knn_pkg::ST_DRAIN: begin
        if (pv_valid && pv_flags.last_cand) begin
          state_d = knn_pkg::ST_EMIT;
          k_lat_d = k_eff;
          cnt_d   = '0;
        end
      end
      knn_pkg::ST_EMIT: begin
        if (load) begin
          cnt_d = cnt_q + KW'(1);
        end
        if (load_last) begin
          state_d = knn_pkg::ST_RUN;
        end
      end
      default: begin
        state_d = knn_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= knn_pkg::ST_RUN;
      k_lat_q <= KW'(1);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      k_lat_q <= k_lat_d;
      cnt_q   <= cnt_d;
    end
  end

  // chain of sorted cells
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    logic [knn_pkg::DIST_BITS-1:0] p_dist, n_dist;
    logic [LABEL_BITS-1:0]         p_label, n_label;
    logic                          p_valid, p_take, n_valid;

    if (i == 0) begin : g_head
      assign p_dist  = knn_pkg::DIST_MAX;
      assign p_label = '0;
      assign p_valid = 1'b0;
      assign p_take  = 1'b0;
    end else begin : g_body
      assign p_dist  = c_dist[i-1];
      assign p_label = c_label[i-1];
      assign p_valid = c_valid[i-1];
      assign p_take  = c_take[i-1];
    end

    if (i == K_MAX - 1) begin : g_tail
      assign n_dist  = knn_pkg::DIST_MAX;
      assign n_label = '0;
      assign n_valid = 1'b0;
    end else begin : g_mid
      assign n_dist  = c_dist[i+1];
      assign n_label = c_label[i+1];
      assign n_valid = c_valid[i+1];
    end

    knn_cell #(
      .LabelBits(LABEL_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .new_dist_i  (pv_dist),
      .new_label_i (pv_label),
      .prev_dist_i (p_dist),
      .prev_label_i(p_label),
      .prev_valid_i(p_valid),
      .prev_take_i (p_take),
      .next_dist_i (n_dist),
      .next_label_i(n_label),
      .next_valid_i(n_valid),
      .dist_o      (c_dist[i]),
      .label_o     (c_label[i]),
      .valid_o     (c_valid[i]),
      .take_o      (c_take[i])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_dist_q  <= c_dist[0];
      out_label_q <= c_label[0];
      out_fill_q  <= c_valid[0];
      out_last_q  <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OutPad{1'b0}}, out_label_q, out_dist_q};
  assign m_axis_tuser  = out_fill_q;
  assign m_axis_tlast  = out_last_q;

  // no input is taken while the list is being emitted
  ast_no_input_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == knn_pkg::ST_EMIT) |-> !s_axis_tready)
    else $error("input accepted during emission");

  // the final result of a query returns the block to streaming
  ast_last_returns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_last |=> (state_q == knn_pkg::ST_RUN) && m_axis_tlast && m_axis_tvalid)
    else $error("emission did not finish on the last neighbour");

  // the chain head is empty after the clearing step
  ast_clear_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> !c_valid[0])
    else $error("chain head still filled after clear");

  // the head pair of the chain stays in ascending order
  if (K_MAX > 1) begin : g_sort_chk
    ast_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
      c_valid[1] |-> c_valid[0] && (c_dist[0] <= c_dist[1]))
      else $error("chain head out of order");
  end

endmodule

`default_nettype wire
